// File: sv/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared codes for the linear envelope generator: event kinds, phases and
// configuration register indexes.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int KIND_W  = 2;
    localparam int PHASE_W = 3;
    localparam int REG_W   = 3;

    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTEOFF = 2'd2;

    localparam logic [PHASE_W-1:0] PH_OFF     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    localparam logic [REG_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [REG_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [REG_W-1:0] REG_RELEASE = 3'd2;
    localparam logic [REG_W-1:0] REG_START   = 3'd3;
    localparam logic [REG_W-1:0] REG_PEAK    = 3'd4;
    localparam logic [REG_W-1:0] REG_HOLD    = 3'd5;

    typedef logic [PHASE_W-1:0] t_phase;

endpackage

// File: sv/adsr_envelope_linear_top.sv
// ----------------------------------------------------------------------------
// adsr_envelope_linear_top
// Linear attack/decay/sustain/release envelope generator with a shared
// add/subtract unit for the ramp multiply and divide.
//
//   channel  dir  handshake                  payload
//   in       in   i_in_valid / o_in_stall    i_kind, i_note_held
//   out      out  o_out_valid / i_out_stall  o_level, o_phase
//   cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a ramp tick runs the serial shift-add multiply and restoring divide
// on the one shared adder
// a sustain, idle or off tick skips the ramp
// restart and note-off words finish in their accept cycle, no output word
// a finished word waits in the output register while i_out_stall is high
// synchronous active-low reset: position 0, phase off, registers to defaults
// ----------------------------------------------------------------------------
module adsr_envelope_linear_top
    import adsr_pkg::*;
#(
    parameter int TIME_BITS  = 16,
    parameter int LEVEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic                  i_note_held,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LEVEL_BITS-1:0] o_level,
    output logic [PHASE_W-1:0]    o_phase,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [REG_W-1:0]      i_cfg_index,
    input  logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] i_cfg_data
);

    localparam int LEN_W = TIME_BITS + 1;
    localparam int POS_W = TIME_BITS + 2;
    localparam int PW    = LEVEL_BITS + LEN_W;
    localparam int CNT_W = $clog2(LEVEL_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]            r_state;
    logic [TIME_BITS-1:0]  r_attack, r_decay, r_release;
    logic [LEVEL_BITS-1:0] r_start, r_peak, r_hold;
    logic [POS_W-1:0]      r_pos;
    t_phase                r_phase;
    logic                  r_held;
    logic [POS_W-1:0]      r_ad;
    logic [POS_W-1:0]      r_off;
    logic [LEN_W-1:0]      r_len;
    logic [LEVEL_BITS-1:0] r_from, r_to, r_span, r_res;
    logic                  r_desc;
    logic [PW-1:0]         r_acc;
    logic [LEN_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    logic [LEVEL_BITS-1:0] r_out_level;
    t_phase                r_out_phase;

    logic [LEN_W-1:0] len_a, len_d, len_r;
    logic [POS_W-1:0] total, pos_inc;
    logic             in_acc;
    logic [PW-1:0]    alu_a, alu_b;
    logic             alu_sub;
    logic [PW:0]      alu_res;
    logic [LEN_W:0]   div_shift;

    assign len_a   = {1'b0, r_attack} + LEN_W'(1);
    assign len_d   = {1'b0, r_decay} + LEN_W'(1);
    assign len_r   = {1'b0, r_release} + LEN_W'(1);
    assign total   = r_ad + POS_W'(len_r);
    assign pos_inc = r_pos + POS_W'(1);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_phase     = r_out_phase;

    assign div_shift = {r_rem, r_acc[LEVEL_BITS-1]};

    // shared adder: shift-add multiply, then restoring divide
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_MUL: begin
                alu_a = {r_acc[PW-2:0], 1'b0};
                alu_b = r_span[r_cnt] ? PW'(r_off[LEN_W-1:0]) : '0;
            end
            S_DIV: begin
                alu_a   = PW'(div_shift);
                alu_b   = PW'(r_len);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (PW + 1)'(alu_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_decay   <= '0;
            r_release <= '0;
            r_start   <= '0;
            r_peak    <= LEVEL_BITS'(255);
            r_hold    <= LEVEL_BITS'(128);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ATTACK:  r_attack  <= i_cfg_data[TIME_BITS-1:0];
                REG_DECAY:   r_decay   <= i_cfg_data[TIME_BITS-1:0];
                REG_RELEASE: r_release <= i_cfg_data[TIME_BITS-1:0];
                REG_START:   r_start   <= i_cfg_data[LEVEL_BITS-1:0];
                REG_PEAK:    r_peak    <= i_cfg_data[LEVEL_BITS-1:0];
                REG_HOLD:    r_hold    <= i_cfg_data[LEVEL_BITS-1:0];
                default:     r_hold    <= r_hold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_phase     <= PH_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_kind)
                            KIND_TICK: begin
                                r_held  <= i_note_held;
                                r_state <= S_SUM;
                            end
                            KIND_RESTART: begin
                                r_pos   <= POS_W'(1);
                                r_phase <= PH_ATTACK;
                            end
                            KIND_NOTEOFF: begin
                                r_pos <= POS_W'(len_a) + POS_W'(len_d);
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_ad    <= POS_W'(len_a) + POS_W'(len_d);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_pos > total) begin
                        r_phase <= PH_OFF;
                        r_pos   <= '0;
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else if (r_pos >= r_ad) begin
                        if (!r_held) begin
                            r_phase <= PH_RELEASE;
                            r_pos   <= pos_inc;
                            r_off   <= pos_inc - r_ad;
                            r_len   <= len_r;
                            r_from  <= r_hold;
                            r_to    <= '0;
                            r_state <= S_CLAMP;
                        end else begin
                            r_phase <= PH_SUSTAIN;
                            r_res   <= r_hold;
                            r_state <= S_OUT;
                        end
                    end else if (r_pos > POS_W'(len_a)) begin
                        r_phase <= PH_DECAY;
                        r_pos   <= pos_inc;
                        r_off   <= pos_inc - POS_W'(len_a);
                        r_len   <= len_d;
                        r_from  <= r_peak;
                        r_to    <= r_hold;
                        r_state <= S_CLAMP;
                    end else if (r_pos != '0) begin
                        r_phase <= PH_ATTACK;
                        r_pos   <= pos_inc;
                        r_off   <= pos_inc;
                        r_len   <= len_a;
                        r_from  <= r_start;
                        r_to    <= r_peak;
                        r_state <= S_CLAMP;
                    end else begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_CLAMP: begin
                    if (r_off > POS_W'(r_len)) begin
                        r_off <= POS_W'(r_len);
                    end
                    r_desc  <= (r_from > r_to);
                    r_span  <= (r_from > r_to) ? (r_from - r_to) : (r_to - r_from);
                    r_acc   <= '0;
                    r_cnt   <= CNT_W'(LEVEL_BITS - 1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= alu_res[PW-1:0];
                    if (r_cnt == '0) begin
                        r_rem   <= alu_res[PW-1:LEVEL_BITS];
                        r_cnt   <= CNT_W'(LEVEL_BITS - 1);
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DIV: begin
                    if (alu_res[PW]) begin
                        r_rem <= alu_res[LEN_W-1:0];
                    end else begin
                        r_rem <= div_shift[LEN_W-1:0];
                    end
                    r_acc[LEVEL_BITS-1:0] <= {r_acc[LEVEL_BITS-2:0], alu_res[PW]};
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_FIN: begin
                    r_res   <= r_desc ? (r_from - r_acc[LEVEL_BITS-1:0])
                                      : (r_from + r_acc[LEVEL_BITS-1:0]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_res;
                        r_out_phase <= r_phase;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == KIND_TICK) |=> o_in_stall)
        else $error("tick word did not start the sequencer");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == KIND_RESTART) |=> (r_pos == POS_W'(1)) && (r_phase == PH_ATTACK))
        else $error("restart did not set attack at position one");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_phase == PH_OFF) |-> (o_level == '0))
        else $error("nonzero level while off");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear envelope generator. A directed table
// walks reset behavior, every word kind, the idle note-off and register
// extremes, then random note sequences run under several register settings
// and idle/stall mixes. Every output word is checked, field by field, in order,
// against a local envelope predictor or against a typed directed-table row.
// ----------------------------------------------------------------------------
module testbench;
    import adsr_pkg::*;

    localparam int TIME_BITS      = 16;
    localparam int LEVEL_BITS     = 8;
    localparam int CFG_W          = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 2 * (2 * LEVEL_BITS + 6);
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int NUM_SEGS       = 12;
    localparam int WORDS_PER_SEG  = 96;

    localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;
    localparam logic [REG_W-1:0]  REG_UNUSED_LO = 3'd6;
    localparam logic [REG_W-1:0]  REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        t_phase                phase;
    } t_env_word;

    typedef struct packed {
        logic                  is_cfg;
        logic [REG_W-1:0]      idx;
        logic [CFG_W-1:0]      data;
        logic [KIND_W-1:0]     kind;
        logic                  held;
        logic                  typed;
        logic [LEVEL_BITS-1:0] lvl;
        t_phase                ph;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind      = '0;
    logic                  i_note_held = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [LEVEL_BITS-1:0] o_level;
    logic [PHASE_W-1:0]    o_phase;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [REG_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;

    logic [TIME_BITS-1:0]  atk_m1    = '0;
    logic [TIME_BITS-1:0]  dec_m1    = '0;
    logic [TIME_BITS-1:0]  rel_m1    = '0;
    logic [LEVEL_BITS-1:0] lvl_start = '0;
    logic [LEVEL_BITS-1:0] lvl_peak  = 8'd255;
    logic [LEVEL_BITS-1:0] lvl_hold  = 8'd128;
    logic [TIME_BITS+1:0]  env_pos   = '0;
    t_phase                env_phase = PH_OFF;

    t_env_word level_expect_q[$];
    t_env_word out_exp;
    int        err_count      = 0;
    int        words_sent     = 0;
    int        send_idle_pct  = 36;
    int        recv_stall_pct = 36;

    adsr_envelope_linear_top #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("status: fail");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [LEVEL_BITS-1:0] ramp_level(
        input logic [LEVEL_BITS-1:0] from,
        input logic [LEVEL_BITS-1:0] to,
        input logic [TIME_BITS+1:0]  offset,
        input logic [TIME_BITS:0]    len
    );
        logic [LEVEL_BITS-1:0] span;
        logic [TIME_BITS:0]    o;
        logic [31:0]           step;
        span = (from > to) ? from - to : to - from;
        o    = (offset > len) ? len : offset[TIME_BITS:0];
        step = (32'(span) * 32'(o)) / 32'(len);
        return (from > to) ? from - step[LEVEL_BITS-1:0] : from + step[LEVEL_BITS-1:0];
    endfunction

    task automatic envelope_step(
        input  logic [KIND_W-1:0] kind,
        input  logic              held,
        output logic              has_word,
        output t_env_word         word
    );
        logic [TIME_BITS:0]   a_len;
        logic [TIME_BITS:0]   d_len;
        logic [TIME_BITS:0]   r_len;
        logic [TIME_BITS+1:0] ad_len;
        logic [TIME_BITS+1:0] total;
        a_len      = {1'b0, atk_m1} + (TIME_BITS+1)'(1);
        d_len      = {1'b0, dec_m1} + (TIME_BITS+1)'(1);
        r_len      = {1'b0, rel_m1} + (TIME_BITS+1)'(1);
        ad_len     = (TIME_BITS+2)'(a_len) + (TIME_BITS+2)'(d_len);
        total      = ad_len + (TIME_BITS+2)'(r_len);
        has_word   = 1'b0;
        word.level = '0;
        case (kind)
            KIND_RESTART: begin
                env_phase = PH_ATTACK;
                env_pos   = (TIME_BITS+2)'(1);
            end
            KIND_NOTEOFF: begin
                env_pos = ad_len;
            end
            KIND_TICK: begin
                has_word = 1'b1;
                if (env_pos > total) begin
                    env_phase = PH_OFF;
                    env_pos   = '0;
                end else if (env_pos >= ad_len) begin
                    if (!held) begin
                        env_phase  = PH_RELEASE;
                        env_pos    = env_pos + (TIME_BITS+2)'(1);
                        word.level = ramp_level(lvl_hold, '0, env_pos - ad_len, r_len);
                    end else begin
                        env_phase  = PH_SUSTAIN;
                        word.level = lvl_hold;
                    end
                end else if (env_pos > (TIME_BITS+2)'(a_len)) begin
                    env_phase  = PH_DECAY;
                    env_pos    = env_pos + (TIME_BITS+2)'(1);
                    word.level = ramp_level(lvl_peak, lvl_hold,
                                            env_pos - (TIME_BITS+2)'(a_len), d_len);
                end else if (env_pos != '0) begin
                    env_phase  = PH_ATTACK;
                    env_pos    = env_pos + (TIME_BITS+2)'(1);
                    word.level = ramp_level(lvl_start, lvl_peak, env_pos, a_len);
                end
            end
            default: ;
        endcase
        word.phase = env_phase;
    endtask

    task automatic send_word(
        input logic [KIND_W-1:0]     kind,
        input logic                  held,
        input logic                  typed       = 1'b0,
        input logic [LEVEL_BITS-1:0] typed_level = '0,
        input t_phase                typed_phase = PH_OFF
    );
        t_env_word pred;
        logic      has_word;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_note_held <= held;
        do @(posedge i_clk); while (o_in_stall);
        envelope_step(kind, held, has_word, pred);
        if (typed) begin
            pred.level = typed_level;
            pred.phase = typed_phase;
        end
        if (has_word) level_expect_q.push_back(pred);
        if (kind != KIND_SPARE) words_sent++;
    endtask

    task automatic write_reg(
        input logic [REG_W-1:0] idx,
        input logic [CFG_W-1:0] data,
        input logic             last
    );
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ATTACK:  atk_m1    = data[TIME_BITS-1:0];
            REG_DECAY:   dec_m1    = data[TIME_BITS-1:0];
            REG_RELEASE: rel_m1    = data[TIME_BITS-1:0];
            REG_START:   lvl_start = data[LEVEL_BITS-1:0];
            REG_PEAK:    lvl_peak  = data[LEVEL_BITS-1:0];
            REG_HOLD:    lvl_hold  = data[LEVEL_BITS-1:0];
            default: ;
        endcase
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (level_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_len(input int seg);
        if (seg == 0) return '0;
        if (seg == 1) return '1;
        if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 65535));
        return CFG_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [CFG_W-1:0] pick_level(input int seg);
        if (seg == 0) return '0;
        if (seg == 1) return '1;
        return CFG_W'($urandom());
    endfunction

    function automatic t_dir_row cfg_row(input logic [REG_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_dir_row word_row(input logic [KIND_W-1:0] kind, input logic held);
        t_dir_row r;
        r      = '0;
        r.kind = kind;
        r.held = held;
        return r;
    endfunction

    function automatic t_dir_row check_row(input logic [KIND_W-1:0] kind, input logic held,
                                           input logic [LEVEL_BITS-1:0] lvl, input t_phase ph);
        t_dir_row r;
        r       = word_row(kind, held);
        r.typed = 1'b1;
        r.lvl   = lvl;
        r.ph    = ph;
        return r;
    endfunction

    always @(posedge i_clk) i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_expect_q.size() == 0) begin
                report("output word with nothing expected");
            end else begin
                out_exp = level_expect_q.pop_front();
                if (o_level !== out_exp.level)
                    report($sformatf("level got %0d exp %0d", o_level, out_exp.level));
                if (o_phase !== out_exp.phase)
                    report($sformatf("phase got %0d exp %0d", o_phase, out_exp.phase));
            end
        end
    end

    initial begin : stimulus
        t_dir_row dir_rows[$];
        t_dir_row row;
        int       target;
        int       n;
        dir_rows = '{
            check_row(KIND_TICK, 1'b0, 8'd0, PH_OFF),
            word_row(KIND_SPARE, 1'b1),
            word_row(KIND_RESTART, 1'b1),
            check_row(KIND_TICK, 1'b1, 8'd255, PH_ATTACK),
            check_row(KIND_TICK, 1'b1, 8'd128, PH_SUSTAIN),
            check_row(KIND_TICK, 1'b0, 8'd0, PH_RELEASE),
            check_row(KIND_TICK, 1'b0, 8'd0, PH_RELEASE),
            check_row(KIND_TICK, 1'b1, 8'd0, PH_OFF),
            check_row(KIND_TICK, 1'b0, 8'd0, PH_OFF),
            word_row(KIND_NOTEOFF, 1'b1),
            check_row(KIND_TICK, 1'b1, 8'd128, PH_SUSTAIN),
            check_row(KIND_TICK, 1'b0, 8'd0, PH_RELEASE),
            cfg_row(REG_ATTACK, 16'd3),
            cfg_row(REG_DECAY, 16'd3),
            cfg_row(REG_RELEASE, 16'd3),
            cfg_row(REG_START, 16'hFF0A),
            cfg_row(REG_PEAK, 16'h00C8),
            cfg_row(REG_HOLD, 16'h0032),
            cfg_row(REG_UNUSED_LO, 16'hFFFF),
            cfg_row(REG_UNUSED_HI, 16'h5A5A),
            word_row(KIND_TICK, 1'b1),
            word_row(KIND_RESTART, 1'b0),
            word_row(KIND_TICK, 1'b1),
            word_row(KIND_TICK, 1'b1),
            word_row(KIND_TICK, 1'b1),
            word_row(KIND_TICK, 1'b1),
            word_row(KIND_TICK, 1'b1),
            word_row(KIND_NOTEOFF, 1'b0),
            word_row(KIND_TICK, 1'b0),
            word_row(KIND_TICK, 1'b0),
            cfg_row(REG_ATTACK, 16'hFFFF),
            cfg_row(REG_START, 16'h00FF),
            cfg_row(REG_PEAK, 16'h0000),
            cfg_row(REG_HOLD, 16'hFFFF),
            word_row(KIND_RESTART, 1'b1),
            word_row(KIND_TICK, 1'b1),
            word_row(KIND_TICK, 1'b0)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                if (i == 0 || !dir_rows[i-1].is_cfg) wait_idle();
                write_reg(row.idx, row.data, (i + 1 == dir_rows.size()) || !dir_rows[i+1].is_cfg);
            end else begin
                send_word(row.kind, row.held, row.typed, row.lvl, row.ph);
            end
        end

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            wait_idle();
            write_reg(REG_ATTACK, pick_len(seg), 1'b0);
            write_reg(REG_DECAY, pick_len(seg), 1'b0);
            write_reg(REG_RELEASE, pick_len(seg), 1'b0);
            write_reg(REG_START, pick_level(seg), 1'b0);
            write_reg(REG_PEAK, pick_level(seg), 1'b0);
            write_reg(REG_HOLD, pick_level(seg), 1'b0);
            write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                      CFG_W'($urandom()), 1'b1);

            target = words_sent + WORDS_PER_SEG;
            while (words_sent < target) begin
                if ($urandom_range(0, 9) < 8) begin
                    // note: restart, held ticks, optional note-off, release ticks
                    send_word(KIND_RESTART, 1'($urandom_range(0, 1)));
                    n = $urandom_range(1, 20);
                    repeat (n) send_word(KIND_TICK, 1'($urandom_range(0, 15) != 0));
                    if ($urandom_range(0, 1)) send_word(KIND_NOTEOFF, 1'($urandom_range(0, 1)));
                    n = $urandom_range(1, 20);
                    repeat (n) send_word(KIND_TICK, 1'b0);
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_word(KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                end
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
